[src/chgs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chgs_pkg
// Shared types and constants for the Graham-scan convex hull block.
// ----------------------------------------------------------------------------
package chgs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;
  localparam int IO_BITS    = 32;
  localparam int IW         = $clog2(MAX_POINTS);
  localparam int CW         = $clog2(MAX_POINTS + 1);
  localparam int DW         = COORD_BITS + 1;      // coordinate difference
  localparam int PW         = 2 * DW;              // product
  localparam int AW         = 2 * COORD_BITS + 4;  // accumulator
  localparam int STEP_BITS  = 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] point_x;
    logic signed [IO_BITS-1:0] point_y;
    logic                      last_point;
  } in_req_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] hull_x;
    logic signed [IO_BITS-1:0] hull_y;
    logic                      hull_last;
    logic                      overflow_seen;
  } out_rsp_t;

  typedef enum logic [2:0] {
    MUL_UXWY,
    MUL_UYWX,
    MUL_UXUX,
    MUL_UYUY,
    MUL_WXWX,
    MUL_WYWY
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    WS_V,
    WS_Q,
    WS_S,
    WS_BEST
  } wk_wsel_t;

  typedef struct packed {
    logic           st_we;
    logic [IW-1:0]  st_waddr;
    logic [IW-1:0]  st_raddr;
    logic           wk_we;
    logic [IW-1:0]  wk_waddr;
    wk_wsel_t       wk_wsel;
    logic [IW-1:0]  wk_raddr;
    logic           sk_we;
    logic [IW-1:0]  sk_waddr;
    logic [IW-1:0]  sk_wdata;
    logic [IW-1:0]  sk_raddr;
    logic           ld_v;
    logic           v_from_store;
    logic           ld_q;
    logic           ld_t;
    logic           ld_s;
    logic           ld_best;
    logic           ld_piv;
    logic           op_ld;
    logic           op_scan;
    mul_sel_t       mul_sel;
    acc_op_t        acc_op;
    logic           ld_out;
    logic           out_last;
    logic           out_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic          eq;
    logic          lower;
    logic          acc_neg;
    logic          acc_zero;
    logic [IW-1:0] sk_rd;
  } dp_sts_t;

endpackage

[src/convex_hull_graham_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Graham-scan convex hull of up to MAX_POINTS points, vertices emitted in
// counter-clockwise order from the pivot.
// ----------------------------------------------------------------------------
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | in_req  (point_x, point_y, last_point)
//   out_    | out | out_valid/out_stall| out_rsp (hull_x, hull_y, hull_last,
//           |     |                    |          overflow_seen)
// Points load at one per cycle. After the final point the block stalls its
// input while it builds the hull: duplicate removal, the angle sort by
// insertion (one shared multiplier, squared lengths compared when collinear),
// the scan tests, and then the vertex output, which also waits on out_stall.
// Synchronous active-low reset returns the block to loading an empty set.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  chgs_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output chgs_pkg::out_rsp_t out_rsp
);

  chgs_pkg::dp_cmd_t cmd;
  chgs_pkg::dp_sts_t sts;
  chgs_pkg::pt_t     in_pt;

  assign in_pt.x = in_req.point_x[chgs_pkg::COORD_BITS-1:0];
  assign in_pt.y = in_req.point_y[chgs_pkg::COORD_BITS-1:0];

  chgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_req.last_point),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  chgs_dp u_dp (
    .clk     (clk),
    .in_pt   (in_pt),
    .cmd     (cmd),
    .sts     (sts),
    .out_rsp (out_rsp)
  );

endmodule

[src/chgs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chgs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[src/chgs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chgs_dp
// Datapath: point, work and stack memories, point registers, one shared
// multiplier with accumulator for cross products and squared lengths.
// ----------------------------------------------------------------------------
module chgs_dp (
  input  logic               clk,
  input  chgs_pkg::pt_t      in_pt,
  input  chgs_pkg::dp_cmd_t  cmd,
  output chgs_pkg::dp_sts_t  sts,
  output chgs_pkg::out_rsp_t out_rsp
);

  chgs_pkg::pt_t st_rd, wk_rd, wk_wdata;
  logic [chgs_pkg::IW-1:0] sk_rd;

  chgs_pkg::pt_t v_r, q_r, t_r, s_r, best_r, piv_r;
  logic signed [chgs_pkg::DW-1:0] ux_r, uy_r, wx_r, wy_r;
  logic signed [chgs_pkg::DW-1:0] ux_nxt, uy_nxt, wx_nxt, wy_nxt;
  logic signed [chgs_pkg::DW-1:0] opa, opb;
  logic signed [chgs_pkg::PW-1:0] prod_r;
  logic signed [chgs_pkg::AW-1:0] acc_r, acc_nxt;
  chgs_pkg::out_rsp_t out_r;

  chgs_ram #(.WIDTH(2 * chgs_pkg::COORD_BITS), .DEPTH(chgs_pkg::MAX_POINTS)) u_store (
    .clk     (clk),
    .wr_en   (cmd.st_we),
    .wr_addr (cmd.st_waddr),
    .wr_data (in_pt),
    .rd_addr (cmd.st_raddr),
    .rd_data (st_rd)
  );

  chgs_ram #(.WIDTH(2 * chgs_pkg::COORD_BITS), .DEPTH(chgs_pkg::MAX_POINTS)) u_work (
    .clk     (clk),
    .wr_en   (cmd.wk_we),
    .wr_addr (cmd.wk_waddr),
    .wr_data (wk_wdata),
    .rd_addr (cmd.wk_raddr),
    .rd_data (wk_rd)
  );

  chgs_ram #(.WIDTH(chgs_pkg::IW), .DEPTH(chgs_pkg::MAX_POINTS)) u_stack (
    .clk     (clk),
    .wr_en   (cmd.sk_we),
    .wr_addr (cmd.sk_waddr),
    .wr_data (cmd.sk_wdata),
    .rd_addr (cmd.sk_raddr),
    .rd_data (sk_rd)
  );

  always_comb begin
    case (cmd.wk_wsel)
      chgs_pkg::WS_V:    wk_wdata = v_r;
      chgs_pkg::WS_Q:    wk_wdata = q_r;
      chgs_pkg::WS_S:    wk_wdata = s_r;
      chgs_pkg::WS_BEST: wk_wdata = best_r;
      default:           wk_wdata = v_r;
    endcase
  end

  // sort: v and q relative to pivot; scan: (t - s) x (v - t)
  always_comb begin
    if (cmd.op_scan) begin
      ux_nxt = chgs_pkg::DW'(t_r.x) - chgs_pkg::DW'(s_r.x);
      uy_nxt = chgs_pkg::DW'(t_r.y) - chgs_pkg::DW'(s_r.y);
      wx_nxt = chgs_pkg::DW'(v_r.x) - chgs_pkg::DW'(t_r.x);
      wy_nxt = chgs_pkg::DW'(v_r.y) - chgs_pkg::DW'(t_r.y);
    end else begin
      ux_nxt = chgs_pkg::DW'(v_r.x) - chgs_pkg::DW'(piv_r.x);
      uy_nxt = chgs_pkg::DW'(v_r.y) - chgs_pkg::DW'(piv_r.y);
      wx_nxt = chgs_pkg::DW'(q_r.x) - chgs_pkg::DW'(piv_r.x);
      wy_nxt = chgs_pkg::DW'(q_r.y) - chgs_pkg::DW'(piv_r.y);
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      chgs_pkg::MUL_UXWY: begin opa = ux_r; opb = wy_r; end
      chgs_pkg::MUL_UYWX: begin opa = uy_r; opb = wx_r; end
      chgs_pkg::MUL_UXUX: begin opa = ux_r; opb = ux_r; end
      chgs_pkg::MUL_UYUY: begin opa = uy_r; opb = uy_r; end
      chgs_pkg::MUL_WXWX: begin opa = wx_r; opb = wx_r; end
      chgs_pkg::MUL_WYWY: begin opa = wy_r; opb = wy_r; end
      default:            begin opa = ux_r; opb = wy_r; end
    endcase
  end

  always_comb begin
    case (cmd.acc_op)
      chgs_pkg::ACC_HOLD: acc_nxt = acc_r;
      chgs_pkg::ACC_LOAD: acc_nxt = chgs_pkg::AW'(prod_r);
      chgs_pkg::ACC_ADD:  acc_nxt = acc_r + chgs_pkg::AW'(prod_r);
      chgs_pkg::ACC_SUB:  acc_nxt = acc_r - chgs_pkg::AW'(prod_r);
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    acc_r  <= acc_nxt;
    if (cmd.ld_v) begin
      v_r <= cmd.v_from_store ? st_rd : wk_rd;
    end
    if (cmd.ld_q) begin
      q_r <= wk_rd;
    end
    if (cmd.ld_t) begin
      t_r <= wk_rd;
    end
    if (cmd.ld_s) begin
      s_r <= wk_rd;
    end
    if (cmd.ld_best) begin
      best_r <= wk_rd;
    end
    if (cmd.ld_piv) begin
      piv_r <= best_r;
    end
    if (cmd.op_ld) begin
      ux_r <= ux_nxt;
      uy_r <= uy_nxt;
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
    end
    if (cmd.ld_out) begin
      out_r.hull_x        <= chgs_pkg::IO_BITS'(wk_rd.x);
      out_r.hull_y        <= chgs_pkg::IO_BITS'(wk_rd.y);
      out_r.hull_last     <= cmd.out_last;
      out_r.overflow_seen <= cmd.out_ovf;
    end
  end

  assign sts.eq       = (wk_rd == v_r);
  assign sts.lower    = (wk_rd.y < best_r.y) || ((wk_rd.y == best_r.y) && (wk_rd.x < best_r.x));
  assign sts.acc_neg  = acc_r[chgs_pkg::AW-1];
  assign sts.acc_zero = (acc_r == '0);
  assign sts.sk_rd    = sk_rd;
  assign out_rsp      = out_r;

endmodule

[src/chgs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chgs_ctrl
// Sequencer: load, duplicate removal, pivot search, insertion sort by angle,
// Graham scan and vertex output.
// ----------------------------------------------------------------------------
module chgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output chgs_pkg::dp_cmd_t cmd,
  input  chgs_pkg::dp_sts_t sts
);

  typedef enum logic [21:0] {
    S_LOAD   = 22'd1 << 0,
    S_DD_RD  = 22'd1 << 1,
    S_DD_V   = 22'd1 << 2,
    S_DD_J   = 22'd1 << 3,
    S_DD_CMP = 22'd1 << 4,
    S_PV_RD  = 22'd1 << 5,
    S_PV_LD  = 22'd1 << 6,
    S_PV_J   = 22'd1 << 7,
    S_PV_CMP = 22'd1 << 8,
    S_PV_SW  = 22'd1 << 9,
    S_PV_SW2 = 22'd1 << 10,
    S_SO_I   = 22'd1 << 11,
    S_SO_V   = 22'd1 << 12,
    S_SO_J   = 22'd1 << 13,
    S_SO_Q   = 22'd1 << 14,
    S_SO_X   = 22'd1 << 15,
    S_SO_D   = 22'd1 << 16,
    S_SC_I   = 22'd1 << 17,
    S_SC_W   = 22'd1 << 18,
    S_SC_T   = 22'd1 << 19,
    S_SC_X   = 22'd1 << 20,
    S_EM     = 22'd1 << 21
  } state_t;

  localparam logic [chgs_pkg::CW-1:0] ONE = chgs_pkg::CW'(1);
  localparam logic [chgs_pkg::CW-1:0] TWO = chgs_pkg::CW'(2);
  localparam logic [chgs_pkg::CW-1:0] CAP = chgs_pkg::CW'(chgs_pkg::MAX_POINTS);

  state_t state_r, state_nxt;
  logic [chgs_pkg::CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [chgs_pkg::CW-1:0] k_r, k_nxt, dep_r, dep_nxt;
  logic [chgs_pkg::IW-1:0] piv_r, piv_nxt;
  logic [chgs_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic ovf_r, ovf_nxt, oval_r, oval_nxt;
  logic [chgs_pkg::CW-1:0] jm1, depm1, depm2, kp1;

  assign jm1   = j_r - ONE;
  assign depm1 = dep_r - ONE;
  assign depm2 = dep_r - TWO;
  assign kp1   = k_r + ONE;

  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    dep_nxt   = dep_r;
    piv_nxt   = piv_r;
    step_nxt  = step_r + 1'b1;
    ovf_nxt   = ovf_r;
    oval_nxt  = oval_r;

    cmd              = '0;
    cmd.st_waddr     = cnt_r[chgs_pkg::IW-1:0];
    cmd.st_raddr     = i_r[chgs_pkg::IW-1:0];
    cmd.wk_wsel      = chgs_pkg::WS_V;
    cmd.sk_waddr     = dep_r[chgs_pkg::IW-1:0];
    cmd.sk_wdata     = i_r[chgs_pkg::IW-1:0];
    cmd.mul_sel      = chgs_pkg::MUL_UXWY;
    cmd.acc_op       = chgs_pkg::ACC_HOLD;
    cmd.out_ovf      = ovf_r;
    cmd.out_last     = (kp1 == dep_r);

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CAP) begin
            cmd.st_we = 1'b1;
            cnt_nxt   = cnt_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            n_nxt     = '0;
            state_nxt = S_DD_RD;
          end
        end
      end

      // duplicate removal into the work memory
      S_DD_RD: begin
        if (i_r == cnt_r) begin
          state_nxt = S_PV_RD;
        end else begin
          state_nxt = S_DD_V;
        end
      end
      S_DD_V: begin
        cmd.ld_v         = 1'b1;
        cmd.v_from_store = 1'b1;
        j_nxt            = '0;
        state_nxt        = S_DD_J;
      end
      S_DD_J: begin
        cmd.wk_raddr = j_r[chgs_pkg::IW-1:0];
        if (j_r == n_r) begin
          cmd.wk_we    = 1'b1;
          cmd.wk_waddr = n_r[chgs_pkg::IW-1:0];
          n_nxt        = n_r + ONE;
          i_nxt        = i_r + ONE;
          state_nxt    = S_DD_RD;
        end else begin
          state_nxt = S_DD_CMP;
        end
      end
      S_DD_CMP: begin
        if (sts.eq) begin
          i_nxt     = i_r + ONE;
          state_nxt = S_DD_RD;
        end else begin
          j_nxt     = j_r + ONE;
          state_nxt = S_DD_J;
        end
      end

      // pivot: least y, then least x
      S_PV_RD: begin
        cmd.wk_raddr = '0;
        state_nxt    = S_PV_LD;
      end
      S_PV_LD: begin
        cmd.ld_best = 1'b1;
        cmd.ld_s    = 1'b1;
        piv_nxt     = '0;
        j_nxt       = ONE;
        state_nxt   = S_PV_J;
      end
      S_PV_J: begin
        cmd.wk_raddr = j_r[chgs_pkg::IW-1:0];
        state_nxt    = (j_r == n_r) ? S_PV_SW : S_PV_CMP;
      end
      S_PV_CMP: begin
        if (sts.lower) begin
          cmd.ld_best = 1'b1;
          piv_nxt     = j_r[chgs_pkg::IW-1:0];
        end
        j_nxt     = j_r + ONE;
        state_nxt = S_PV_J;
      end
      S_PV_SW: begin
        cmd.wk_we    = 1'b1;
        cmd.wk_waddr = piv_r;
        cmd.wk_wsel  = chgs_pkg::WS_S;
        state_nxt    = S_PV_SW2;
      end
      S_PV_SW2: begin
        cmd.wk_we    = 1'b1;
        cmd.wk_waddr = '0;
        cmd.wk_wsel  = chgs_pkg::WS_BEST;
        cmd.ld_piv   = 1'b1;
        i_nxt        = TWO;
        state_nxt    = S_SO_I;
      end

      // insertion sort by polar angle
      S_SO_I: begin
        cmd.wk_raddr = i_r[chgs_pkg::IW-1:0];
        j_nxt        = i_r;
        if (i_r >= n_r) begin
          i_nxt     = '0;
          dep_nxt   = '0;
          state_nxt = S_SC_I;
        end else begin
          state_nxt = S_SO_V;
        end
      end
      S_SO_V: begin
        cmd.ld_v  = 1'b1;
        state_nxt = S_SO_J;
      end
      S_SO_J: begin
        cmd.wk_raddr = jm1[chgs_pkg::IW-1:0];
        cmd.wk_waddr = j_r[chgs_pkg::IW-1:0];
        if (j_r <= ONE) begin
          cmd.wk_we = 1'b1;
          i_nxt     = i_r + ONE;
          state_nxt = S_SO_I;
        end else begin
          state_nxt = S_SO_Q;
        end
      end
      S_SO_Q: begin
        cmd.ld_q  = 1'b1;
        step_nxt  = '1;
        state_nxt = S_SO_X;
      end
      S_SO_X: begin
        // step 7 loads operands, 0..2 form u x w, then its sign decides
        cmd.wk_waddr = j_r[chgs_pkg::IW-1:0];
        case (step_r)
          3'd7: cmd.op_ld = 1'b1;
          3'd0: cmd.mul_sel = chgs_pkg::MUL_UXWY;
          3'd1: begin
            cmd.mul_sel = chgs_pkg::MUL_UYWX;
            cmd.acc_op  = chgs_pkg::ACC_LOAD;
          end
          3'd2: cmd.acc_op = chgs_pkg::ACC_SUB;
          default: begin
            if (sts.acc_zero) begin
              step_nxt  = '0;
              state_nxt = S_SO_D;
            end else if (!sts.acc_neg) begin
              cmd.wk_we   = 1'b1;
              cmd.wk_wsel = chgs_pkg::WS_Q;
              j_nxt       = jm1;
              state_nxt   = S_SO_J;
            end else begin
              cmd.wk_we = 1'b1;
              i_nxt     = i_r + ONE;
              state_nxt = S_SO_I;
            end
          end
        endcase
      end
      S_SO_D: begin
        // collinear: compare squared lengths
        cmd.wk_waddr = j_r[chgs_pkg::IW-1:0];
        case (step_r)
          3'd0: cmd.mul_sel = chgs_pkg::MUL_UXUX;
          3'd1: begin
            cmd.mul_sel = chgs_pkg::MUL_UYUY;
            cmd.acc_op  = chgs_pkg::ACC_LOAD;
          end
          3'd2: begin
            cmd.mul_sel = chgs_pkg::MUL_WXWX;
            cmd.acc_op  = chgs_pkg::ACC_ADD;
          end
          3'd3: begin
            cmd.mul_sel = chgs_pkg::MUL_WYWY;
            cmd.acc_op  = chgs_pkg::ACC_SUB;
          end
          3'd4: cmd.acc_op = chgs_pkg::ACC_SUB;
          default: begin
            cmd.wk_we = 1'b1;
            if (sts.acc_neg) begin
              cmd.wk_wsel = chgs_pkg::WS_Q;
              j_nxt       = jm1;
              state_nxt   = S_SO_J;
            end else begin
              i_nxt     = i_r + ONE;
              state_nxt = S_SO_I;
            end
          end
        endcase
      end

      // Graham scan
      S_SC_I: begin
        cmd.wk_raddr = i_r[chgs_pkg::IW-1:0];
        if (i_r == n_r) begin
          k_nxt     = '0;
          step_nxt  = '0;
          state_nxt = S_EM;
        end else begin
          step_nxt  = '0;
          state_nxt = S_SC_W;
        end
      end
      S_SC_W: begin
        // step 0 takes v from the read issued in S_SC_I
        cmd.ld_v = (step_r == 3'd0);
        if (dep_r < TWO) begin
          cmd.sk_we = 1'b1;
          dep_nxt   = dep_r + ONE;
          i_nxt     = i_r + ONE;
          state_nxt = S_SC_I;
        end else begin
          cmd.sk_raddr = depm1[chgs_pkg::IW-1:0];
          step_nxt     = '0;
          state_nxt    = S_SC_T;
        end
      end
      S_SC_T: begin
        cmd.sk_raddr = depm2[chgs_pkg::IW-1:0];
        cmd.wk_raddr = sts.sk_rd;
        case (step_r)
          3'd0: ;
          3'd1: cmd.ld_t = 1'b1;
          default: begin
            cmd.ld_s  = 1'b1;
            step_nxt  = '1;
            state_nxt = S_SC_X;
          end
        endcase
      end
      S_SC_X: begin
        cmd.op_scan = 1'b1;
        case (step_r)
          3'd7: cmd.op_ld = 1'b1;
          3'd0: cmd.mul_sel = chgs_pkg::MUL_UXWY;
          3'd1: begin
            cmd.mul_sel = chgs_pkg::MUL_UYWX;
            cmd.acc_op  = chgs_pkg::ACC_LOAD;
          end
          3'd2: cmd.acc_op = chgs_pkg::ACC_SUB;
          default: begin
            step_nxt = 3'd1;
            if (sts.acc_neg || sts.acc_zero) begin
              dep_nxt   = depm1;
              state_nxt = S_SC_W;
            end else begin
              cmd.sk_we = 1'b1;
              dep_nxt   = dep_r + ONE;
              i_nxt     = i_r + ONE;
              state_nxt = S_SC_I;
            end
          end
        endcase
      end

      // output: stack read, work read, load, hand over
      S_EM: begin
        cmd.sk_raddr = k_r[chgs_pkg::IW-1:0];
        cmd.wk_raddr = sts.sk_rd;
        case (step_r)
          3'd0, 3'd1: ;
          3'd2: begin
            cmd.ld_out = 1'b1;
            oval_nxt   = 1'b1;
          end
          default: begin
            step_nxt = step_r;
            if (!out_stall) begin
              oval_nxt = 1'b0;
              step_nxt = '0;
              k_nxt    = kp1;
              if (kp1 == dep_r) begin
                cnt_nxt   = '0;
                ovf_nxt   = 1'b0;
                state_nxt = S_LOAD;
              end
            end
          end
        endcase
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      dep_r   <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dep_r   <= dep_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    piv_r <= piv_nxt;
  end

endmodule

[verif/tb_convex_hull_graham_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_convex_hull_graham_scan
// Sends point sets through the hull block with random gaps and output stalls.
// Each set's hull is predicted with exact integer geometry and then checked
// vertex by vertex.
// ----------------------------------------------------------------------------
module tb_convex_hull_graham_scan;

  typedef struct {
    longint x;
    longint y;
  } gpt_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  chgs_pkg::in_req_t  in_req;
  logic               out_valid;
  logic               out_stall;
  chgs_pkg::out_rsp_t out_rsp;

  convex_hull_graham_scan u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_rsp  (out_rsp)
  );

  chgs_pkg::in_req_t  point_q[$];
  chgs_pkg::out_rsp_t hull_q[$];
  gpt_t     set_pts[$];
  logic     set_ovf;
  int       errors;
  int       accepted;
  int       queued;
  int       vertices_seen;
  int       in_gap;
  int       out_gap;
  int       hold_left;
  bit       hold_done;
  bit       in_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact sign of (ax,ay) x (bx,by)
  function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
    logic signed [127:0] a, b, c, d, l, r;
    a = ax; b = by; c = ay; d = bx;
    l = a * b;
    r = c * d;
    return (l > r) ? 1 : ((l < r) ? -1 : 0);
  endfunction

  function automatic logic signed [127:0] dist2(longint dx, longint dy);
    logic signed [127:0] a, b;
    a = dx; b = dy;
    return a * a + b * b;
  endfunction

  function automatic bit angle_first(gpt_t a, gpt_t b, gpt_t pv);
    int s;
    s = cross_sgn(a.x - pv.x, a.y - pv.y, b.x - pv.x, b.y - pv.y);
    if (s != 0) return s > 0;
    return dist2(a.x - pv.x, a.y - pv.y) < dist2(b.x - pv.x, b.y - pv.y);
  endfunction

  task automatic build_hull();
    gpt_t    w[$];
    gpt_t    tmp, v, t, s;
    int      stk[$];
    int      k, j;
    bit      dup;
    chgs_pkg::out_rsp_t r;
    foreach (set_pts[i]) begin
      dup = 0;
      foreach (w[m]) if (w[m].x == set_pts[i].x && w[m].y == set_pts[i].y) dup = 1;
      if (!dup) w.insert(w.size(), set_pts[i]);
    end
    k = 0;
    for (int i = 1; i < w.size(); i++)
      if (w[i].y < w[k].y || (w[i].y == w[k].y && w[i].x < w[k].x)) k = i;
    tmp = w[0]; w[0] = w[k]; w[k] = tmp;
    for (int i = 2; i < w.size(); i++) begin
      v = w[i];
      j = i;
      while (j > 1 && angle_first(v, w[j-1], w[0])) begin
        w[j] = w[j-1];
        j--;
      end
      w[j] = v;
    end
    for (int i = 0; i < w.size(); i++) begin
      while (stk.size() >= 2) begin
        t = w[stk[stk.size()-1]];
        s = w[stk[stk.size()-2]];
        if (cross_sgn(t.x - s.x, t.y - s.y, w[i].x - t.x, w[i].y - t.y) <= 0)
          stk.delete(stk.size() - 1);
        else
          break;
      end
      stk.insert(stk.size(), i);
    end
    foreach (stk[m]) begin
      r.hull_x        = w[stk[m]].x[31:0];
      r.hull_y        = w[stk[m]].y[31:0];
      r.hull_last     = (m == stk.size() - 1);
      r.overflow_seen = set_ovf;
      hull_q.insert(hull_q.size(), r);
    end
    set_pts.delete();
    set_ovf = 1'b0;
  endtask

  task automatic take_point(chgs_pkg::in_req_t r);
    gpt_t p;
    p.x = longint'(r.point_x);
    p.y = longint'(r.point_y);
    if (set_pts.size() < chgs_pkg::MAX_POINTS) set_pts.insert(set_pts.size(), p);
    else set_ovf = 1'b1;
    if (r.last_point) build_hull();
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request side: next request presented at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_req <= point_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && vertices_seen >= 20) begin
        hold_done <= 1'b1;
        hold_left <= 600;
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      take_point(in_req);
      accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      vertices_seen++;
      if (hull_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected vertex: expected none, actual %p", $time, out_rsp);
      end else if (hull_q[0] !== out_rsp) begin
        errors++;
        $display("%0t: vertex mismatch: expected %p, actual %p", $time, hull_q[0], out_rsp);
        void'(hull_q.pop_front());
      end else begin
        void'(hull_q.pop_front());
      end
    end
  end

  task automatic add_point(longint x, longint y, bit last);
    chgs_pkg::in_req_t r;
    r.point_x = x[31:0];
    r.point_y = y[31:0];
    r.last_point = last;
    point_q.insert(point_q.size(), r);
    queued++;
  endtask

  function automatic longint rnd_coord(int mode);
    case (mode)
      0: return longint'($urandom_range(0, 8)) - 4;
      1: return longint'(signed'($urandom));
      default: return longint'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  task automatic random_set(int n, int mode);
    longint bx, by, dx, dy, k;
    bx = rnd_coord(2); by = rnd_coord(2);
    dx = rnd_coord(0); dy = rnd_coord(0);
    for (int i = 0; i < n; i++) begin
      if (mode == 3) begin
        // points along one line, some repeated
        k = $urandom_range(0, 6);
        add_point(bx + k * dx, by + k * dy, i == n - 1);
      end else begin
        add_point(rnd_coord(mode), rnd_coord(mode), i == n - 1);
      end
    end
  endtask

  initial begin
    longint mx, mn;
    rst_n = 1'b0; in_valid = 1'b0; in_req = '0; out_stall = 1'b0;
    errors = 0; accepted = 0; queued = 0; vertices_seen = 0;
    in_gap = 0; out_gap = 0; hold_left = 0; hold_done = 0; in_taken = 0;
    set_ovf = 1'b0;
    mx = 64'sd2147483647; mn = -64'sd2147483648;
    // single point, then a repeated single point
    add_point(5, -7, 1);
    add_point(3, 3, 0); add_point(3, 3, 0); add_point(3, 3, 1);
    // extremes of both coordinates
    add_point(mn, mn, 0); add_point(mx, mn, 0); add_point(mx, mx, 0);
    add_point(mn, mx, 0); add_point(0, 0, 1);
    // collinear, with duplicates and nearer points
    add_point(4, 4, 0); add_point(0, 0, 0); add_point(2, 2, 0);
    add_point(4, 4, 0); add_point(1, 1, 1);
    // square with interior and edge points, tie on lowest y
    add_point(2, 0, 0); add_point(0, 0, 0); add_point(2, 2, 0);
    add_point(1, 1, 0); add_point(0, 2, 0); add_point(1, 0, 0); add_point(0, 1, 1);
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // random sets, mostly small, then one large set that overflows
    while (queued < 115) begin
      case ($urandom_range(0, 9))
        0, 1:    random_set($urandom_range(1, 6), 0);
        2, 3, 4: random_set($urandom_range(3, 12), 1);
        5, 6:    random_set($urandom_range(3, 10), 2);
        7, 8:    random_set($urandom_range(2, 8), 3);
        default: random_set($urandom_range(1, 4), 1);
      endcase
    end
    random_set(67, 0);
    while (accepted < queued || hull_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
